@@ hdl/pds_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_pkg
// Shared widths, codes and types of the pedal dead-band scaler.
// ----------------------------------------------------------------------------
package pds_pkg;

  localparam int SAMPLE_W    = 8;
  localparam int VALUE_W     = 7;
  localparam int STATUS_W    = 2;
  localparam int OP_W        = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  // window sum of three samples
  localparam int SUM_W       = SAMPLE_W + 2;
  // (sample - low) * 127 fits in SAMPLE_W + VALUE_W bits
  localparam int DIV_NUM_W   = SAMPLE_W + VALUE_W;
  localparam int DIV_REM_W   = SAMPLE_W;
  localparam int DIV_CNT_W   = 4;

  localparam logic [DIV_CNT_W-1:0] MEAN_STEPS  = DIV_CNT_W'(SUM_W);
  localparam logic [DIV_CNT_W-1:0] SCALE_STEPS = DIV_CNT_W'(VALUE_W);

  localparam logic [OP_W-1:0] OP_SAMPLE    = 2'd0;
  localparam logic [OP_W-1:0] OP_CAL_START = 2'd1;
  localparam logic [OP_W-1:0] OP_CAL_STOP  = 2'd2;

  localparam logic [STATUS_W-1:0] CAL_NONE    = 2'd0;
  localparam logic [STATUS_W-1:0] CAL_APPLIED = 2'd1;
  localparam logic [STATUS_W-1:0] CAL_DEFAULT = 2'd2;
  localparam logic [STATUS_W-1:0] CAL_KEPT    = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_IS_PRIMARY = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BOOT_MIN   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BOOT_MAX   = 2'd2;

  localparam logic [SAMPLE_W-1:0] BOOT_MIN_RST = 8'd0;
  localparam logic [SAMPLE_W-1:0] BOOT_MAX_RST = 8'd127;
  localparam logic [VALUE_W-1:0]  VALUE_MAX    = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MEAN,
    S_CHECK,
    S_SCALE,
    S_DONE
  } pds_state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
    logic [DIV_REM_W-1:0] rem_init;
    logic [DIV_NUM_W-1:0] num;
    logic [SAMPLE_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
  } div_sts_t;

  typedef struct packed {
    logic                clear;
    logic                mark;
    logic [SAMPLE_W-1:0] sample;
  } cal_cmd_t;

  typedef struct packed {
    logic                enough;
    logic [SAMPLE_W-1:0] low;
    logic [SAMPLE_W-1:0] high;
  } cal_sts_t;

endpackage

@@ hdl/pds_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_in_if
// Input channel: operation code and raw pedal sample.
// ----------------------------------------------------------------------------
interface pds_in_if import pds_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output op, output sample, input ready);
  modport sink   (input valid, input op, input sample, output ready);
endinterface

@@ hdl/pds_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_out_if
// Output channel: scaled pedal value and calibration status.
// ----------------------------------------------------------------------------
interface pds_out_if import pds_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                valid_res;
  logic [VALUE_W-1:0]  value;
  logic [STATUS_W-1:0] cal_status;

  modport source (output valid, output valid_res, output value, output cal_status,
                  input ready);
  modport sink   (input valid, input valid_res, input value, input cal_status,
                  output ready);
endinterface

@@ hdl/pds_serial_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_serial_div
// Restoring divider, one quotient bit per cycle, shared by the window mean
// and the span scaling.
// ----------------------------------------------------------------------------
module pds_serial_div import pds_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_sts_t sts
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_REM_W-1:0] rem;
  logic [DIV_NUM_W-1:0] num;
  logic [DIV_NUM_W-1:0] quot;
  logic [SAMPLE_W-1:0]  divisor;

  logic [DIV_REM_W:0]   rem_sh;
  logic                 fits;
  logic [DIV_REM_W:0]   rem_sub;

  // remainder stays below the divisor, so it fits back in DIV_REM_W bits
  assign rem_sh  = {rem, num[DIV_NUM_W-1]};
  assign fits    = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= req.rem_init;
      num     <= req.num;
      divisor <= req.divisor;
      quot    <= '0;
    end else if (busy) begin
      rem  <= fits ? rem_sub[DIV_REM_W-1:0] : rem_sh[DIV_REM_W-1:0];
      num  <= {num[DIV_NUM_W-2:0], 1'b0};
      quot <= {quot[DIV_NUM_W-2:0], fits};
    end
  end

  assign sts.done = done;
  assign sts.quot = quot;

endmodule

@@ hdl/pds_cal_track.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_cal_track
// Calibration tracker: running min and max and a distinct-value count
// that saturates at three.
// ----------------------------------------------------------------------------
module pds_cal_track import pds_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cal_cmd_t cmd,
  output cal_sts_t sts
);

  logic [1:0]          cnt;
  logic [SAMPLE_W-1:0] low;
  logic [SAMPLE_W-1:0] high;
  // first two distinct values seen; a third distinct one saturates the count
  logic [SAMPLE_W-1:0] first;
  logic [SAMPLE_W-1:0] second;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      cnt  <= 2'd0;
      low  <= '1;
      high <= '0;
    end else if (cmd.mark) begin
      if (cmd.sample < low) begin
        low <= cmd.sample;
      end
      if (cmd.sample > high) begin
        high <= cmd.sample;
      end
      case (cnt)
        2'd0: cnt <= 2'd1;
        2'd1: if (cmd.sample != first) cnt <= 2'd2;
        2'd2: if (cmd.sample != first && cmd.sample != second) cnt <= 2'd3;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mark && cnt == 2'd0) begin
      first <= cmd.sample;
    end
    if (cmd.mark && cnt == 2'd1) begin
      second <= cmd.sample;
    end
  end

  assign sts.enough = cnt == 2'd3;
  assign sts.low    = low;
  assign sts.high   = high;

endmodule

@@ hdl/pedal_deadband_scaler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedal_deadband_scaler
// Pedal sample conditioning: dead band around a three-sample mean,
// min/max calibration and linear scaling to 0..127 (inverted).
// ----------------------------------------------------------------------------
// Every input word gives exactly one output word. The block takes one word at
// a time: calibration starts and stops, ignored codes and samples taken during
// calibration go from acceptance straight to S_DONE; a sample outside
// calibration passes S_CHECK and may use the bit-serial divider, which
// produces one quotient bit per cycle: the window mean on every third sample
// takes 10 quotient bits (S_MEAN, before S_CHECK) and the span scaling of a
// sample outside the dead band and inside the span takes 7 quotient bits
// (S_SCALE, after S_CHECK). The output register holds a finished word
// while the next one is accepted and worked on. Configuration writes (primary
// flag, table minimum, table maximum) load the table directly and are meant
// for times when the block is idle.
// ----------------------------------------------------------------------------
module pedal_deadband_scaler import pds_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  pds_in_if.sink                 in_ch,
  pds_out_if.source              out_ch,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data
);

  pds_state_t state, state_next;

  logic                accept;
  logic [SAMPLE_W-1:0] smp_q;

  logic [SAMPLE_W-1:0] window0;
  logic [SAMPLE_W-1:0] window1;
  logic [1:0]          phase;
  logic [SAMPLE_W-1:0] mean;
  logic                in_cal;
  logic                is_primary;
  logic [SAMPLE_W-1:0] table_low;
  logic [SAMPLE_W-1:0] table_high;

  logic                res_valid;
  logic [VALUE_W-1:0]  res_value;
  logic [STATUS_W-1:0] res_status;

  logic                out_valid;
  logic                out_valid_res;
  logic [VALUE_W-1:0]  out_value;
  logic [STATUS_W-1:0] out_status;
  logic                out_free;
  logic                out_load;

  logic                phase_wrap;
  logic                mean_start;
  logic [SUM_W-1:0]    sum;

  logic                far;
  logic [SAMPLE_W+1:0] span;
  logic                span_pos;
  logic [SAMPLE_W:0]   lo;
  logic                s_ge_lo;
  logic [SAMPLE_W-1:0] diff;
  logic                diff_ge_span;
  logic                scale_need;
  logic [VALUE_W-1:0]  r_direct;
  logic [DIV_NUM_W-1:0] prod;

  div_req_t div_req;
  div_sts_t div_sts;
  cal_cmd_t cal_cmd;
  cal_sts_t cal_sts;

  assign accept     = in_ch.valid && in_ch.ready;
  assign phase_wrap = phase == 2'd2;
  assign sum        = SUM_W'(in_ch.sample) + SUM_W'(window0) + SUM_W'(window1);
  assign mean_start = accept && in_ch.op == OP_SAMPLE && !in_cal && phase_wrap;

  // dead band and scaling terms, used in S_CHECK
  assign far = ({1'b0, smp_q} > {1'b0, mean} + (SAMPLE_W+1)'(2)) ||
               ({1'b0, smp_q} + (SAMPLE_W+1)'(2) < {1'b0, mean});
  assign span = {2'b00, table_high} - {2'b00, table_low} - (SAMPLE_W+2)'(8);
  assign span_pos     = !span[SAMPLE_W+1] && span != '0;
  assign lo           = {1'b0, table_low} + (SAMPLE_W+1)'(4);
  assign s_ge_lo      = {1'b0, smp_q} >= lo;
  assign diff         = smp_q - lo[SAMPLE_W-1:0];
  assign diff_ge_span = diff >= span[SAMPLE_W-1:0];
  assign scale_need   = far && span_pos && s_ge_lo && !diff_ge_span;
  // diff * 127 as a shift and subtract
  assign prod = {diff, VALUE_W'(0)} - DIV_NUM_W'(diff);

  always_comb begin
    if (!span_pos) begin
      r_direct = s_ge_lo ? VALUE_MAX : '0;
    end else if (!s_ge_lo) begin
      r_direct = '0;
    end else begin
      r_direct = VALUE_MAX;
    end
  end

  assign out_free = !out_valid || out_ch.ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.op == OP_SAMPLE && !in_cal) begin
            state_next = phase_wrap ? S_MEAN : S_CHECK;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_MEAN:  if (div_sts.done) state_next = S_CHECK;
      S_CHECK: state_next = scale_need ? S_SCALE : S_DONE;
      S_SCALE: if (div_sts.done) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // state machine outputs
  always_comb begin
    in_ch.ready      = 1'b0;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.steps    = MEAN_STEPS;
    div_req.rem_init = '0;
    div_req.num      = {sum, (DIV_NUM_W-SUM_W)'(0)};
    div_req.divisor  = SAMPLE_W'(3);
    unique case (state)
      S_IDLE: begin
        in_ch.ready   = 1'b1;
        div_req.start = mean_start;
      end
      S_CHECK: begin
        div_req.start    = scale_need;
        div_req.steps    = SCALE_STEPS;
        div_req.rem_init = prod[DIV_NUM_W-1:VALUE_W];
        div_req.num      = {prod[VALUE_W-1:0], SAMPLE_W'(0)};
        div_req.divisor  = span[SAMPLE_W-1:0];
      end
      S_DONE:  out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window0    <= '0;
      window1    <= '0;
      phase      <= 2'd0;
      mean       <= '0;
      in_cal     <= 1'b0;
      is_primary <= 1'b1;
      table_low  <= BOOT_MIN_RST;
      table_high <= BOOT_MAX_RST;
    end else begin
      if (accept) begin
        case (in_ch.op)
          OP_SAMPLE: begin
            if (!in_cal) begin
              window1 <= window0;
              window0 <= in_ch.sample;
              phase   <= phase_wrap ? 2'd0 : phase + 2'd1;
            end
          end
          OP_CAL_START: in_cal <= 1'b1;
          OP_CAL_STOP: begin
            in_cal <= 1'b0;
            if (cal_sts.enough) begin
              table_low  <= cal_sts.low;
              table_high <= cal_sts.high;
            end else if (is_primary) begin
              table_low  <= BOOT_MIN_RST;
              table_high <= BOOT_MAX_RST;
            end
          end
          default: ;
        endcase
      end
      if (state == S_MEAN && div_sts.done) begin
        mean <= div_sts.quot[SAMPLE_W-1:0];
      end
      if (wr_en) begin
        case (wr_index)
          REG_IS_PRIMARY: is_primary <= wr_data[0];
          REG_BOOT_MIN:   table_low  <= wr_data;
          REG_BOOT_MAX:   table_high <= wr_data;
          default: ;
        endcase
      end
    end
  end

  // pending result word
  always_ff @(posedge clk) begin
    if (accept) begin
      smp_q      <= in_ch.sample;
      res_valid  <= 1'b0;
      res_value  <= '0;
      res_status <= CAL_NONE;
      if (in_ch.op == OP_CAL_STOP) begin
        if (cal_sts.enough) begin
          res_status <= CAL_APPLIED;
        end else if (is_primary) begin
          res_status <= CAL_DEFAULT;
        end else begin
          res_status <= CAL_KEPT;
        end
      end
    end
    if (state == S_CHECK && far) begin
      res_valid <= 1'b1;
      res_value <= ~r_direct;
    end
    if (state == S_SCALE && div_sts.done) begin
      res_value <= ~div_sts.quot[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_valid_res <= res_valid;
      out_value     <= res_value;
      out_status    <= res_status;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.valid_res  = out_valid_res;
  assign out_ch.value      = out_value;
  assign out_ch.cal_status = out_status;

  assign cal_cmd.clear  = accept && in_ch.op == OP_CAL_START;
  assign cal_cmd.mark   = accept && in_ch.op == OP_SAMPLE && in_cal;
  assign cal_cmd.sample = in_ch.sample;

  pds_serial_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .sts (div_sts)
  );

  pds_cal_track u_cal (
    .clk (clk),
    .rst (rst),
    .cmd (cal_cmd),
    .sts (cal_sts)
  );

endmodule

@@ hdl/pds_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pds_checker
// Port-level checks of the pedal dead-band scaler, bound to the top level.
// ----------------------------------------------------------------------------
module pds_checker import pds_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic                valid_res,
  input logic [VALUE_W-1:0]  value,
  input logic [STATUS_W-1:0] cal_status
);

  // one word in flight: the input closes right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted word");

  // a word without a scaled value carries value zero
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> value == '0)
    else $error("value nonzero on a word without a scaled value");

  // calibration status and a scaled value never come together
  a_status_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && cal_status != CAL_NONE |-> !valid_res)
    else $error("calibration status on a word with a scaled value");

  // hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(cal_status))
    else $error("stalled output word dropped or changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind pedal_deadband_scaler pds_checker u_pds_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .valid_res  (out_ch.valid_res),
  .value      (out_ch.value),
  .cal_status (out_ch.cal_status)
);
